/* rtl/hsdsv_pkg.sv */
// Shared types, constants and helper functions of the HMAC-SHA256 sign/verify block.
// Used by the compression unit and the top level; depends on nothing else.
package hsdsv_pkg;

	typedef logic [31:0] word_t;

	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5c;
	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [7:0] SEP_Q     = 8'h71;
	localparam logic [7:0] SEP_C     = 8'h63;
	localparam logic [7:0] SEP_1     = 8'h31;
	localparam logic [7:0] SEP_U     = 8'h75;
	localparam logic [7:0] SEP_D     = 8'h64;

	localparam logic [63:0] OUTER_LEN_BITS = 64'd768;

	localparam logic MODE_SIGN   = 1'b0;
	localparam logic MODE_VERIFY = 1'b1;

	localparam logic KIND_TAG     = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [255:0] INIT_H = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Sequencer commands to the compression unit
	typedef struct packed {
		logic       feed;
		logic [7:0] data;
		logic       load;
		logic       round;
		logic [5:0] rnd;
		logic       add;
		logic       init;
	} sha_ctl_t;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_KEYI   = 13'b0000000000010,
		S_SEP    = 13'b0000000000100,
		S_MSG    = 13'b0000000001000,
		S_P80    = 13'b0000000010000,
		S_PZ     = 13'b0000000100000,
		S_PLEN   = 13'b0000001000000,
		S_OSTART = 13'b0000010000000,
		S_OKEY   = 13'b0000100000000,
		S_DIG    = 13'b0001000000000,
		S_COMP   = 13'b0010000000000,
		S_ADD    = 13'b0100000000000,
		S_OUT    = 13'b1000000000000
	} state_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

/* rtl/hsdsv_sha_unit.sv */
// SHA-256 compression unit: byte-fed block window, one round per cycle, chaining value.
// Driven by the sequencer in the top level; depends on hsdsv_pkg.
module hsdsv_sha_unit (
	input  logic              clk,
	input  hsdsv_pkg::sha_ctl_t ctl,
	output logic [255:0]      hash
);
	import hsdsv_pkg::*;

	logic [511:0] win_q;
	word_t        v_q [8];
	word_t        h_q [8];

	word_t w0, w1, w9, w14, w_new;
	word_t s0, s1, e1, ch, a0, mj, t1, t2;

	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];

	always_comb begin
		s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		w_new = w0 + s0 + w9 + s1;
		e1    = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1    = v_q[7] + e1 + ch + ROUND_K[ctl.rnd] + w0;
		a0    = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2    = a0 + mj;
	end

	always_ff @(posedge clk) begin
		if (ctl.feed) begin
			win_q <= {win_q[503:0], ctl.data};
		end else if (ctl.round) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (ctl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (ctl.init) begin
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[255 - 32 * i -: 32];
		end else if (ctl.add) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) hash[255 - 32 * i -: 32] = h_q[i];
	end

endmodule

/* rtl/hmac_sha256_domain_sign_verify_core.sv */
// Top level of the HMAC-SHA256 domain-separated sign/verify block: APB key registers,
// byte sequencer and result port. Depends on hsdsv_pkg and hsdsv_sha_unit.
//
// Usage: write the eight 64-bit key words over APB (byte address 8*i) while idle.
// Stream one beat per message byte on the s_ side; the first beat of a message fixes
// mode and direction (tuser), tlast marks the final beat, which also carries the
// signature in verify mode. Sign mode returns four tag beats (tlast on the fourth),
// verify mode one verdict beat; tuser on the m_ side tells which.
// Work per beat: each beat feeds at most one byte, plus one compression for each 64-byte block
// that it completes. The first beat of a message adds 64 key bytes, 4 separator bytes
// and one compression. The last beat adds inner padding with one or two compressions,
// 64 opad bytes, 32 digest bytes and 32 padding bytes with two more compressions.
// A single round unit does one SHA-256 round per cycle. s_tready is high only while
// the block is idle.
// While m_tready is low the result beat holds and no new beat is taken.
// Reset clears the key registers and aborts any message in progress.
module hmac_sha256_domain_sign_verify_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [271:0]  s_tdata,  // msg_byte, byte_present, sig_word_0..3, zero fill
	input  logic [1:0]    s_tuser,  // mode, direction
	input  logic          s_tlast,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [71:0]   m_tdata,  // tag_word, word_index, match, zero fill
	output logic          m_tuser,  // result_kind
	output logic          m_tlast
);
	import hsdsv_pkg::*;

	logic [63:0]  key_q [8];
	logic [511:0] key_flat;
	state_t       state_q, ret_q, nxt;
	logic [5:0]   cnt_q, pos_q, rnd_q;
	logic [63:0]  bitlen_q, len_q;
	logic         busy_q, mode_q, dir_q, outer_q;
	logic [511:0] wkey_q;
	logic [255:0] dig_q, sig_q, hash;
	logic [7:0]   msgb_q;
	logic         pres_q, last_q;
	logic [1:0]   oidx_q;
	logic         feed, fill, phase_done, s_acc, m_acc, inner_feed;
	logic [7:0]   fbyte, sep_byte;
	sha_ctl_t     ctl;

	assign pready   = 1'b1;
	assign prdata   = key_q[paddr[5:3]];
	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (state_q == S_OUT);
	assign m_acc    = m_tvalid && m_tready;

	always_comb begin
		for (int i = 0; i < 8; i++) key_flat[511 - 64 * i -: 64] = key_q[i];
	end

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sep_byte = SEP_Q;
			2'd1:    sep_byte = SEP_C;
			2'd2:    sep_byte = SEP_1;
			default: sep_byte = dir_q ? SEP_D : SEP_U;
		endcase
	end

	// Byte source and phase order
	always_comb begin
		feed       = 1'b0;
		fbyte      = 8'h00;
		phase_done = 1'b0;
		nxt        = state_q;
		unique case (state_q)
			S_KEYI: begin
				feed       = 1'b1;
				fbyte      = wkey_q[511:504] ^ IPAD_BYTE;
				phase_done = (cnt_q == 6'd63);
				if (phase_done) nxt = S_SEP;
			end
			S_SEP: begin
				feed       = 1'b1;
				fbyte      = sep_byte;
				phase_done = (cnt_q == 6'd3);
				if (phase_done) nxt = S_MSG;
			end
			S_MSG: begin
				feed  = pres_q;
				fbyte = msgb_q;
				nxt   = last_q ? S_P80 : S_IDLE;
			end
			S_P80: begin
				feed  = 1'b1;
				fbyte = PAD_BYTE;
				nxt   = S_PZ;
			end
			S_PZ: begin
				feed = (pos_q != 6'd56);
				if (!feed) nxt = S_PLEN;
			end
			S_PLEN: begin
				feed       = 1'b1;
				fbyte      = len_q[63:56];
				phase_done = (cnt_q == 6'd7);
				if (phase_done) nxt = outer_q ? S_OUT : S_OSTART;
			end
			S_OSTART: nxt = S_OKEY;
			S_OKEY: begin
				feed       = 1'b1;
				fbyte      = wkey_q[511:504] ^ OPAD_BYTE;
				phase_done = (cnt_q == 6'd63);
				if (phase_done) nxt = S_DIG;
			end
			S_DIG: begin
				feed       = 1'b1;
				fbyte      = dig_q[255:248];
				phase_done = (cnt_q == 6'd31);
				if (phase_done) nxt = S_P80;
			end
			S_COMP: if (rnd_q == 6'd63) nxt = S_ADD;
			S_ADD:  nxt = ret_q;
			S_OUT: begin
				if (m_acc && (mode_q == MODE_VERIFY || oidx_q == 2'd3)) nxt = S_IDLE;
			end
			default: begin
				if (s_acc) nxt = busy_q ? S_MSG : S_KEYI;
			end
		endcase
	end

	assign fill       = feed && (pos_q == 6'd63);
	assign inner_feed = feed && (state_q == S_KEYI || state_q == S_SEP || state_q == S_MSG);

	always_comb begin
		ctl.feed  = feed;
		ctl.data  = fbyte;
		ctl.load  = fill;
		ctl.round = (state_q == S_COMP);
		ctl.rnd   = rnd_q;
		ctl.add   = (state_q == S_ADD);
		ctl.init  = (s_acc && !busy_q) || (state_q == S_OSTART);
	end

	hsdsv_sha_unit u_sha (
		.clk  (clk),
		.ctl  (ctl),
		.hash (hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			rnd_q   <= '0;
			busy_q  <= 1'b0;
			mode_q  <= 1'b0;
			dir_q   <= 1'b0;
			outer_q <= 1'b0;
			oidx_q  <= '0;
			for (int i = 0; i < 8; i++) key_q[i] <= '0;
		end else begin
			if (psel && penable && pwrite && pready) key_q[paddr[5:3]] <= pwdata;
			// hand a full block to the round unit, then resume where the feed left off
			if (fill) begin
				state_q <= S_COMP;
				ret_q   <= nxt;
				rnd_q   <= '0;
			end else begin
				state_q <= nxt;
			end
			if (state_q == S_COMP) rnd_q <= rnd_q + 6'd1;
			if (feed) begin
				pos_q <= pos_q + 6'd1;
				cnt_q <= phase_done ? 6'd0 : cnt_q + 6'd1;
			end
			// restart the byte count for the length field
			if (state_q == S_PZ && !feed) cnt_q <= '0;
			if (s_acc && !busy_q) begin
				busy_q  <= 1'b1;
				mode_q  <= s_tuser[0];
				dir_q   <= s_tuser[1];
				outer_q <= 1'b0;
				pos_q   <= '0;
				cnt_q   <= '0;
			end
			if (state_q == S_OSTART) outer_q <= 1'b1;
			if (m_acc) begin
				if (nxt == S_IDLE) begin
					busy_q <= 1'b0;
					oidx_q <= '0;
				end else begin
					oidx_q <= oidx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			msgb_q <= s_tdata[7:0];
			pres_q <= s_tdata[8];
			last_q <= s_tlast;
			sig_q  <= {s_tdata[72:9], s_tdata[136:73], s_tdata[200:137], s_tdata[264:201]};
		end
		if (s_acc && !busy_q) begin
			bitlen_q <= '0;
			wkey_q   <= key_flat;
		end else if (state_q == S_OSTART) begin
			wkey_q <= key_flat;
			dig_q  <= hash;
		end else begin
			if (inner_feed) bitlen_q <= bitlen_q + 64'd8;
			if (feed && (state_q == S_KEYI || state_q == S_OKEY)) wkey_q <= wkey_q << 8;
			if (feed && state_q == S_DIG) dig_q <= dig_q << 8;
		end
		if (state_q == S_P80) len_q <= outer_q ? OUTER_LEN_BITS : bitlen_q;
		else if (state_q == S_PLEN) len_q <= len_q << 8;
	end

	always_comb begin
		m_tdata = '0;
		if (mode_q == MODE_VERIFY) begin
			m_tuser     = KIND_VERDICT;
			m_tlast     = 1'b1;
			m_tdata[66] = (hash == sig_q);
		end else begin
			m_tuser        = KIND_TAG;
			m_tlast        = (oidx_q == 2'd3);
			m_tdata[63:0]  = hash[255 - 64 * oidx_q -: 64];
			m_tdata[65:64] = oidx_q;
		end
	end

endmodule

/* rtl/hsdsv_checker.sv */
// Port-level checks for the HMAC-SHA256 sign/verify block, bound to its top level.
// Depends only on the top level's ports.
module hsdsv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// no new beat is taken while a result is pending
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input accepted while result pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_verdict_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata[65:0] == 66'd0)
		else $error("verdict beat malformed");

	a_tag_nomatch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tdata[66] && (m_tlast == (m_tdata[65:64] == 2'd3)))
		else $error("tag beat malformed");

	// the beat after a non-final tag word that was taken is the next word
	a_tag_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tuser && !m_tlast |=>
		m_tvalid && !m_tuser && m_tdata[65:64] == $past(m_tdata[65:64]) + 2'd1)
		else $error("tag words out of order");

endmodule

bind hmac_sha256_domain_sign_verify_core hsdsv_checker u_hsdsv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
